>>> hw/rtl/ble_pkg.sv
`timescale 1ns / 1ps

package ble_pkg;

	// field and format widths
	localparam int FRAC_BITS  = 16;
	localparam int VOLT_W     = 13;
	localparam int FIX_W      = VOLT_W + FRAC_BITS;
	localparam int PCT_W      = 7;
	localparam int ALPHA_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int ADC_WIDTH_DEF = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA = 1'b1;

	// register reset values
	localparam logic [VOLT_W-1:0]  FULL_SCALE_RST = 13'd6600;
	localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd6554;

	// charge curve breakpoints
	localparam int TABLE_POINTS = 6;
	localparam int SEG_W        = $clog2(TABLE_POINTS);
	localparam logic [SEG_W-1:0] FIRST_SEG = SEG_W'(1);
	localparam logic [SEG_W-1:0] LAST_SEG  = SEG_W'(TABLE_POINTS - 1);

	typedef struct packed {
		logic             done;
		logic [FIX_W-1:0] value;
	} fix_res_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] pct;
	} pct_res_t;

	typedef struct packed {
		logic scale;
		logic smooth;
		logic pct;
	} unit_start_t;

	// breakpoint voltage in millivolts
	function automatic logic [VOLT_W-1:0] lvl_mv(input logic [SEG_W-1:0] idx);
		logic [VOLT_W-1:0] mv;
		case (idx)
			3'd0:    mv = 13'd3100;
			3'd1:    mv = 13'd3550;
			3'd2:    mv = 13'd3650;
			3'd3:    mv = 13'd3800;
			3'd4:    mv = 13'd3950;
			3'd5:    mv = 13'd4150;
			default: mv = 13'd4150;
		endcase
		return mv;
	endfunction

	// breakpoint charge in percent
	function automatic logic [PCT_W-1:0] lvl_pct(input logic [SEG_W-1:0] idx);
		logic [PCT_W-1:0] p;
		case (idx)
			3'd0:    p = 7'd0;
			3'd1:    p = 7'd20;
			3'd2:    p = 7'd40;
			3'd3:    p = 7'd60;
			3'd4:    p = 7'd80;
			3'd5:    p = 7'd100;
			default: p = 7'd100;
		endcase
		return p;
	endfunction

	// breakpoint voltage with fraction bits
	function automatic logic [FIX_W-1:0] lvl_fix(input logic [SEG_W-1:0] idx);
		return {lvl_mv(idx), {FRAC_BITS{1'b0}}};
	endfunction

endpackage

>>> hw/rtl/ble_if.sv
`timescale 1ns / 1ps

// sample channel
interface ble_in_if import ble_pkg::*; #(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [ADC_WIDTH-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

// result channel
interface ble_out_if import ble_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] voltage_mv;
	logic [PCT_W-1:0]  charge_percent;

	modport source (output valid, output voltage_mv, output charge_percent, input ready);
	modport sink (input valid, input voltage_mv, input charge_percent, output ready);
endinterface

>>> hw/rtl/ble_scale.sv
`timescale 1ns / 1ps

module ble_scale import ble_pkg::*; #(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ADC_WIDTH-1:0] sample,
	input  logic [VOLT_W-1:0]    full_scale,
	output fix_res_t             res
);

	localparam int PROD_W = ADC_WIDTH + VOLT_W;
	localparam int CNT_W  = $clog2(ADC_WIDTH + 1);

	logic [ADC_WIDTH-1:0] smp_q;
	logic [VOLT_W-1:0]    fs_q;
	logic [PROD_W-1:0]    acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ADC_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add multiply, one sample bit per cycle, msb first
	always_ff @(posedge clk) begin
		if (start) begin
			smp_q <= sample;
			fs_q  <= full_scale;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << 1) + (smp_q[ADC_WIDTH-1] ? PROD_W'(fs_q) : PROD_W'(0));
			smp_q <= smp_q << 1;
		end
	end

	assign res.done  = done_q;
	assign res.value = FIX_W'(acc_q) << (FRAC_BITS - ADC_WIDTH);

endmodule

>>> hw/rtl/ble_smooth.sv
`timescale 1ns / 1ps

module ble_smooth import ble_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [FIX_W-1:0]   sample_fix,
	input  logic [ALPHA_W-1:0] alpha,
	output fix_res_t           res
);

	localparam int CNT_W = $clog2(ALPHA_W + 1);

	logic [FIX_W-1:0]   filt_q;
	logic               loaded_q;
	logic [FIX_W-1:0]   d_q;
	logic [FIX_W-1:0]   acc_q;
	logic [ALPHA_W-1:0] a_q;
	logic               up_q;
	logic               sticky_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               apply_q;
	logic               done_q;
	logic [FIX_W:0]     sum;

	// one alpha bit per step, lsb first, product shifted right as it builds
	assign sum = {1'b0, acc_q} + ({(FIX_W + 1){a_q[0]}} & {1'b0, d_q});

	// filter state and step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q   <= '0;
			loaded_q <= 1'b0;
			busy_q   <= 1'b0;
			apply_q  <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q  <= 1'b0;
			apply_q <= 1'b0;
			if (start) begin
				if (!loaded_q) begin
					filt_q   <= sample_fix;
					loaded_q <= 1'b1;
					done_q   <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(ALPHA_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q  <= 1'b0;
					apply_q <= 1'b1;
				end
			end else if (apply_q) begin
				// rising: floor of the step, falling: ceiling of the step
				if (up_q) begin
					filt_q <= filt_q + acc_q;
				end else begin
					filt_q <= filt_q - acc_q - FIX_W'(sticky_q);
				end
				done_q <= 1'b1;
			end
		end
	end

	// difference and serial product
	always_ff @(posedge clk) begin
		if (start) begin
			up_q     <= (sample_fix >= filt_q);
			d_q      <= (sample_fix >= filt_q) ? sample_fix - filt_q : filt_q - sample_fix;
			a_q      <= alpha;
			acc_q    <= '0;
			sticky_q <= 1'b0;
		end else if (busy_q) begin
			acc_q    <= sum[FIX_W:1];
			sticky_q <= sticky_q | sum[0];
			a_q      <= a_q >> 1;
		end
	end

	assign res.done  = done_q;
	assign res.value = filt_q;

endmodule

>>> hw/rtl/ble_percent.sv
`timescale 1ns / 1ps

module ble_percent import ble_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [FIX_W-1:0] volt_fix,
	output pct_res_t         res
);

	localparam int NUM_W = FIX_W + PCT_W;
	localparam int DEN_W = FIX_W + PCT_W - 1;
	localparam int CNT_W = $clog2(PCT_W + 1);

	typedef enum logic [1:0] {
		P_IDLE,
		P_SCAN,
		P_MUL,
		P_DIV
	} pstate_t;

	pstate_t           state_q;
	logic [FIX_W-1:0]  v_q;
	logic [SEG_W-1:0]  seg_q;
	logic [FIX_W-1:0]  off_q;
	logic [PCT_W-1:0]  dp_q;
	logic [PCT_W-1:0]  base_q;
	logic [VOLT_W-1:0] span_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [PCT_W-1:0]  q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PCT_W-1:0]  pct_q;
	logic              done_q;
	logic [VOLT_W-1:0] span;
	logic              ge;
	logic [PCT_W-1:0]  q_next;

	assign span   = lvl_mv(seg_q) - lvl_mv(seg_q - SEG_W'(1));
	assign ge     = (num_q >= NUM_W'(den_q));
	assign q_next = {q_q[PCT_W-2:0], ge};

	// clamp, segment scan, multiply, then restoring divide one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
			pct_q   <= '0;
			seg_q   <= FIRST_SEG;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						v_q   <= volt_fix;
						seg_q <= FIRST_SEG;
						if (volt_fix <= lvl_fix('0)) begin
							pct_q  <= lvl_pct('0);
							done_q <= 1'b1;
						end else if (volt_fix >= lvl_fix(LAST_SEG)) begin
							pct_q  <= lvl_pct(LAST_SEG);
							done_q <= 1'b1;
						end else begin
							state_q <= P_SCAN;
						end
					end
				end
				P_SCAN: begin
					if (v_q <= lvl_fix(seg_q)) begin
						if (span == '0) begin
							pct_q   <= lvl_pct(seg_q);
							done_q  <= 1'b1;
							state_q <= P_IDLE;
						end else begin
							off_q   <= v_q - lvl_fix(seg_q - SEG_W'(1));
							dp_q    <= lvl_pct(seg_q) - lvl_pct(seg_q - SEG_W'(1));
							base_q  <= lvl_pct(seg_q - SEG_W'(1));
							span_q  <= span;
							state_q <= P_MUL;
						end
					end else begin
						seg_q <= seg_q + SEG_W'(1);
					end
				end
				P_MUL: begin
					num_q   <= NUM_W'(off_q) * NUM_W'(dp_q);
					den_q   <= DEN_W'({span_q, {FRAC_BITS{1'b0}}}) << (PCT_W - 1);
					q_q     <= '0;
					cnt_q   <= CNT_W'(PCT_W);
					state_q <= P_DIV;
				end
				P_DIV: begin
					if (ge) begin
						num_q <= num_q - NUM_W'(den_q);
					end
					den_q <= den_q >> 1;
					q_q   <= q_next;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						pct_q   <= base_q + q_next;
						done_q  <= 1'b1;
						state_q <= P_IDLE;
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	assign res.done = done_q;
	assign res.pct  = pct_q;

endmodule

>>> hw/rtl/battery_level_estimator.sv
`timescale 1ns / 1ps

// Battery level estimator.
// Samples arrive on sample_ch as raw converter readings; each accepted word
// yields exactly one word on result_ch: the smoothed voltage in whole
// millivolts and a charge estimate of 0 to 100 percent from a fixed curve.
// The scale and the filter weight are written on the cfg port (index 0 full
// scale millivolts, index 1 alpha in Q0.16); the user must write them only
// while no sample is in flight, which the block itself does not enforce.
// One sample is processed at a time. From acceptance to the result register
// a sample passes ADC_WIDTH steps of the bit-serial scaling multiply, 16
// steps of the bit-serial alpha multiply plus an update step, a breakpoint
// scan over up to five segments, a multiply step and a 7-step restoring
// divide. The first sample only loads the filter and clamped voltages skip
// the divide.
// Reset restores both registers and empties the filter; the next sample
// loads it. A new sample is taken while the previous result still waits in
// the output register; if the receiver stalls, a finished result is held
// until that register frees up.
module battery_level_estimator import ble_pkg::*; #(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ble_in_if.sink                sample_ch,
	ble_out_if.source             result_ch
);

	typedef enum logic [2:0] {
		T_IDLE,
		T_SCALE,
		T_SMOOTH,
		T_PCT,
		T_HOLD
	} tstate_t;

	tstate_t            state_q;
	logic [VOLT_W-1:0]  full_scale_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic               out_valid_q;
	logic [VOLT_W-1:0]  volt_q;
	logic [PCT_W-1:0]   pct_q;
	unit_start_t        starts;
	fix_res_t           scale_res;
	fix_res_t           smooth_res;
	pct_res_t           pct_res;
	logic               accept;
	logic               load;

	assign sample_ch.ready = (state_q == T_IDLE);
	assign accept          = sample_ch.valid && sample_ch.ready;

	assign starts.scale  = accept;
	assign starts.smooth = (state_q == T_SCALE) && scale_res.done;
	assign starts.pct    = (state_q == T_SMOOTH) && smooth_res.done;

	// result goes out once the output register is free
	assign load = (((state_q == T_PCT) && pct_res.done) || (state_q == T_HOLD))
		&& (!out_valid_q || result_ch.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RST;
			alpha_q      <= ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FULL_SCALE:   full_scale_q <= cfg_data[VOLT_W-1:0];
				REG_SMOOTH_ALPHA: alpha_q      <= cfg_data[ALPHA_W-1:0];
				default:          ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE:   if (accept) state_q <= T_SCALE;
				T_SCALE:  if (scale_res.done) state_q <= T_SMOOTH;
				T_SMOOTH: if (smooth_res.done) state_q <= T_PCT;
				T_PCT: begin
					if (pct_res.done) begin
						state_q <= load ? T_IDLE : T_HOLD;
					end
				end
				T_HOLD:   if (load) state_q <= T_IDLE;
				default:  state_q <= T_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			volt_q <= smooth_res.value[FIX_W-1:FRAC_BITS];
			pct_q  <= pct_res.pct;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.voltage_mv     = volt_q;
	assign result_ch.charge_percent = pct_q;

	ble_scale #(
		.ADC_WIDTH (ADC_WIDTH)
	) u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (starts.scale),
		.sample     (sample_ch.adc_sample),
		.full_scale (full_scale_q),
		.res        (scale_res)
	);

	ble_smooth u_smooth (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (starts.smooth),
		.sample_fix (scale_res.value),
		.alpha      (alpha_q),
		.res        (smooth_res)
	);

	ble_percent u_percent (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (starts.pct),
		.volt_fix (smooth_res.value),
		.res      (pct_res)
	);

`ifndef NO_ASSERTIONS
	// never more than one unit started in a cycle
	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(starts))
		else $error("two units started together");

	// the scale and percent units finish only while the sequencer waits on them
	a_scale_done: assert property (@(posedge clk) disable iff (!arst_n)
		scale_res.done |-> (state_q == T_SCALE))
		else $error("scale done outside its phase");

	a_pct_done: assert property (@(posedge clk) disable iff (!arst_n)
		pct_res.done |-> (state_q == T_PCT))
		else $error("percent done outside its phase");

	// a result load never overwrites a word still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || result_ch.ready))
		else $error("output word overwritten");

	// after a load the sequencer is back to taking samples
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q == T_IDLE) && out_valid_q)
		else $error("sequencer not idle after result load");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ble_pkg::*;

	localparam int ADC_W        = ADC_WIDTH_DEF;
	localparam int KNEES        = 6;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_WORDS  = 250;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 400;
	localparam int PAD_W        = CFG_DATA_W - VOLT_W;

	// charge curve, index 0 is the lowest knee
	localparam logic [KNEES-1:0][VOLT_W-1:0] KNEE_MV =
		{13'd4150, 13'd3950, 13'd3800, 13'd3650, 13'd3550, 13'd3100};
	localparam logic [KNEES-1:0][PCT_W-1:0] KNEE_PCT =
		{7'd100, 7'd80, 7'd60, 7'd40, 7'd20, 7'd0};

	typedef struct packed {
		logic [VOLT_W-1:0] voltage_mv;
		logic [PCT_W-1:0]  charge_percent;
	} reading_t;

	typedef enum logic {ROW_SAMPLE, ROW_SETUP} row_kind_e;

	typedef struct packed {
		row_kind_e          kind;
		logic [ADC_W-1:0]   sample;
		logic [VOLT_W-1:0]  fs;
		logic [ALPHA_W-1:0] alpha;
		logic               typed;
		reading_t           want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ble_in_if #(.ADC_WIDTH(ADC_W)) sample_bus ();
	ble_out_if result_bus ();

	battery_level_estimator #(.ADC_WIDTH(ADC_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_bus.sink),
		.result_ch (result_bus.source)
	);

	// predictor state and register copies
	logic [FIX_W-1:0]   ema_fix = '0;
	logic               ema_primed = 1'b0;
	logic [VOLT_W-1:0]  fs_mv = FULL_SCALE_RST;
	logic [ALPHA_W-1:0] alpha_q16 = ALPHA_RST;

	reading_t estimate_q [$];
	int faults = 0;
	int results_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// sample in millivolts, 16 fraction bits
	function automatic logic [FIX_W-1:0] scaled_sample(input logic [ADC_W-1:0] s);
		logic [63:0] p;
		p = (64'(s) * 64'(fs_mv)) << (FRAC_BITS - ADC_W);
		return p[FIX_W-1:0];
	endfunction

	// one moving average update, floor rounding when rising, ceiling when falling
	function automatic logic [FIX_W-1:0] ema_step(input logic [FIX_W-1:0] prev,
			input logic [FIX_W-1:0] x, input logic [ALPHA_W-1:0] a);
		logic [63:0] d;
		logic [63:0] step;
		if (x >= prev) begin
			d = 64'(x) - 64'(prev);
			step = (64'(a) * d) >> FRAC_BITS;
			return prev + step[FIX_W-1:0];
		end
		d = 64'(prev) - 64'(x);
		step = (64'(a) * d + 64'd65535) >> FRAC_BITS;
		return prev - step[FIX_W-1:0];
	endfunction

	// piecewise linear charge curve, clamped at both ends
	function automatic logic [PCT_W-1:0] charge_of(input logic [FIX_W-1:0] v);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] frac;
		if (v <= {KNEE_MV[0], {FRAC_BITS{1'b0}}})
			return KNEE_PCT[0];
		if (v >= {KNEE_MV[KNEES-1], {FRAC_BITS{1'b0}}})
			return KNEE_PCT[KNEES-1];
		for (int k = 1; k < KNEES; k++) begin
			hi = 64'(KNEE_MV[k]) << FRAC_BITS;
			if (64'(v) <= hi) begin
				lo = 64'(KNEE_MV[k-1]) << FRAC_BITS;
				frac = ((64'(v) - lo) * 64'(KNEE_PCT[k] - KNEE_PCT[k-1])) / (hi - lo);
				return KNEE_PCT[k-1] + PCT_W'(frac);
			end
		end
		return KNEE_PCT[KNEES-1];
	endfunction

	// advance the filter by one sample and give the expected word
	function automatic reading_t estimate_reading(input logic [ADC_W-1:0] s);
		logic [FIX_W-1:0] x;
		reading_t r;
		x = scaled_sample(s);
		if (!ema_primed) begin
			ema_fix = x;
			ema_primed = 1'b1;
		end else begin
			ema_fix = ema_step(ema_fix, x, alpha_q16);
		end
		r.voltage_mv = ema_fix[FIX_W-1:FRAC_BITS];
		r.charge_percent = charge_of(ema_fix);
		return r;
	endfunction

	// mostly voltages around the curve, some full range and rail values
	function automatic logic [ADC_W-1:0] pick_sample();
		int sel;
		longint s;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return '0;
		if (sel < 20)
			return '1;
		if (sel < 40)
			return ADC_W'($urandom);
		s = (longint'($urandom_range(2900, 4350)) << ADC_W) / longint'(fs_mv);
		if (s > (1 << ADC_W) - 1)
			s = (1 << ADC_W) - 1;
		return ADC_W'(s);
	endfunction

	function automatic row_t sample_row(input logic [ADC_W-1:0] s);
		row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.sample = s;
		return r;
	endfunction

	function automatic row_t known_row(input logic [ADC_W-1:0] s,
			input logic [VOLT_W-1:0] v, input logic [PCT_W-1:0] p);
		row_t r;
		r = sample_row(s);
		r.typed = 1'b1;
		r.want.voltage_mv = v;
		r.want.charge_percent = p;
		return r;
	endfunction

	function automatic row_t setup_row(input logic [VOLT_W-1:0] fs, input logic [ALPHA_W-1:0] a);
		row_t r;
		r = '0;
		r.kind = ROW_SETUP;
		r.fs = fs;
		r.alpha = a;
		return r;
	endfunction

	// offer one sample word and record its expected result on acceptance
	task automatic push_sample(input logic [ADC_W-1:0] s, input logic typed,
			input reading_t want);
		reading_t guess;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.adc_sample <= s;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
		guess = estimate_reading(s);
		estimate_q.push_back(typed ? want : guess);
	endtask

	// stop offering and let the block run dry
	task automatic settle();
		sample_bus.valid <= 1'b0;
		while (estimate_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write both registers while idle; spare data bits above full scale are junk
	task automatic load_settings(input logic [VOLT_W-1:0] fs, input logic [ALPHA_W-1:0] a);
		logic [CFG_DATA_W-VOLT_W-1:0] pad;
		settle();
		pad = PAD_W'($urandom_range(0, (1 << PAD_W) - 1));
		cfg_we <= 1'b1;
		cfg_index <= REG_FULL_SCALE;
		cfg_data <= CFG_DATA_W'({pad, fs});
		@(posedge clk);
		cfg_index <= REG_SMOOTH_ALPHA;
		cfg_data <= CFG_DATA_W'(a);
		@(posedge clk);
		cfg_we <= 1'b0;
		fs_mv = fs;
		alpha_q16 = a;
	endtask

	// result side: check each word, random stalls, one long hold-off
	initial begin : result_side
		int hold_left;
		logic held;
		reading_t want;
		hold_left = 0;
		held = 1'b0;
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (estimate_q.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected word: voltage %0d percent %0d",
							result_bus.voltage_mv, result_bus.charge_percent);
				end else begin
					want = estimate_q.pop_front();
					if (result_bus.voltage_mv !== want.voltage_mv ||
							result_bus.charge_percent !== want.charge_percent) begin
						faults++;
						if (faults <= 10)
							$display("word %0d: voltage %0d (exp %0d) percent %0d (exp %0d)",
								results_seen, result_bus.voltage_mv, want.voltage_mv,
								result_bus.charge_percent, want.charge_percent);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// sample side: reset, directed rows, then random phases
	initial begin : sample_side
		row_t plan [0:24];
		logic [VOLT_W-1:0] fs;
		logic [ALPHA_W-1:0] a;
		sample_bus.valid <= 1'b0;
		sample_bus.adc_sample <= '0;

		// rail values, then descents onto each knee below the top one with the fastest
		// filter, then a frozen filter
		plan = '{
			known_row(12'd0, 13'd0, 7'd0),
			sample_row(12'd4095), sample_row(12'd4095), sample_row(12'd2048),
			setup_row(13'd8191, 16'hFFFF),
			sample_row(12'd0), sample_row(12'd0), sample_row(12'd0),
			sample_row(12'd4095), sample_row(12'd4095),
			setup_row(13'd4096, 16'hFFFF),
			sample_row(12'd3950), sample_row(12'd3950), sample_row(12'd3950),
			sample_row(12'd3800), sample_row(12'd3800),
			sample_row(12'd3650), sample_row(12'd3650),
			sample_row(12'd3550), sample_row(12'd3550),
			sample_row(12'd3100), sample_row(12'd3100),
			setup_row(13'd4096, 16'd0),
			sample_row(12'd4095), sample_row(12'd0)
		};

		send_idle_pct = 25;
		recv_idle_pct = 46;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP)
				load_settings(plan[i].fs, plan[i].alpha);
			else
				push_sample(plan[i].sample, plan[i].typed, plan[i].want);
		end

		// random phases over a spread of scale and weight settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					fs = 13'd1000;
					a = 16'd1;
				end
				1: begin
					fs = 13'd8191;
					a = 16'hFFFF;
				end
				3: begin
					fs = 13'd4096;
					a = 16'd0;
				end
				5: begin
					fs = 13'd1000;
					a = 16'hFFFF;
				end
				6: begin
					fs = 13'd8191;
					a = 16'd1;
				end
				default: begin
					fs = VOLT_W'($urandom_range(1000, 8191));
					a = ALPHA_W'($urandom_range(1, 65535));
				end
			endcase
			load_settings(fs, a);
			if (ph < 3) begin
				send_idle_pct = 25;
				recv_idle_pct = 46;
			end else if (ph < 6) begin
				send_idle_pct = 46;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (PHASE_WORDS) push_sample(pick_sample(), 1'b0, '0);
		end

		settle();
		if (faults == 0 && estimate_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ble_pkg.sv
hw/rtl/ble_if.sv
hw/rtl/ble_scale.sv
hw/rtl/ble_smooth.sv
hw/rtl/ble_percent.sv
hw/rtl/battery_level_estimator.sv
dv/testbench.sv
